// ===== design/osc_pkg.sv =====
`default_nettype none

package osc_pkg;

  // tag classes
  localparam logic [2:0] CL_UNKNOWN = 3'd0;
  localparam logic [2:0] CL_FOUR    = 3'd1;
  localparam logic [2:0] CL_EIGHT   = 3'd2;
  localparam logic [2:0] CL_ZERO    = 3'd3;
  localparam logic [2:0] CL_STR     = 3'd4;

  // result kinds
  localparam logic [2:0] K_ADDR = 3'd0;
  localparam logic [2:0] K_ARG  = 3'd1;
  localparam logic [2:0] K_STR  = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_ERR  = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [6:0] TAG_C    = 7'h63;
  localparam logic [6:0] TAG_T    = 7'h54;
  localparam logic [6:0] TAG_I    = 7'h49;

  localparam logic [63:0] INF_BITS = 64'h0000_0000_7F80_0000;
  localparam logic [6:0]  LOW7     = 7'h7F;

  localparam logic [4:0] MAX_RESULTS = 5'd18;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam logic [QAW:0] QFULL = (QAW+1)'(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic [1:0] offset;
    logic [2:0] cls;
    logic       is_slash;
    logic       is_comma;
    logic       is_zero;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  tag;
    logic [3:0]  idx;
    logic [63:0] val;
    logic        last;
  } result_t;

  function automatic logic [2:0] tag_class(input logic [7:0] t);
    logic [2:0] c;
    case (t) inside
      8'h69, 8'h66, 8'h63, 8'h72, 8'h6D: c = CL_FOUR;   // i f c r m
      8'h68, 8'h64, 8'h74:               c = CL_EIGHT;  // h d t
      8'h54, 8'h46, 8'h4E, 8'h49:        c = CL_ZERO;   // T F N I
      8'h73, 8'h53:                      c = CL_STR;    // s S
      default:                           c = CL_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/osc_front.sv =====
`default_nettype none

module osc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          q_full,
  output logic               q_push,
  output osc_pkg::item_t     q_item
);

  logic [1:0] offset;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.data     = s_tdata;
    q_item.eop      = s_tlast;
    q_item.offset   = offset;
    q_item.cls      = osc_pkg::tag_class(s_tdata);
    q_item.is_slash = (s_tdata == osc_pkg::CH_SLASH);
    q_item.is_comma = (s_tdata == osc_pkg::CH_COMMA);
    q_item.is_zero  = (s_tdata == 8'd0);
  end

  // position within the message modulo 4, restarts after the end mark
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 2'd0;
    end else if (q_push) begin
      offset <= s_tlast ? 2'd0 : offset + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== design/osc_queue.sv =====
`default_nettype none

module osc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  osc_pkg::item_t      item_in,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output osc_pkg::item_t      item_out
);

  osc_pkg::item_t         entries [osc_pkg::QDEPTH];
  logic [osc_pkg::QAW-1:0] wr_ptr;
  logic [osc_pkg::QAW-1:0] rd_ptr;
  logic [osc_pkg::QAW:0]   count;

  assign full     = (count == osc_pkg::QFULL);
  assign valid    = (count != '0);
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/osc_back.sv =====
`default_nettype none

module osc_back #(
  parameter int MAX_TAGS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  osc_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output osc_pkg::result_t   out_res
);

  localparam int CW = $clog2(MAX_TAGS + 1);
  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam logic [CW-1:0] MAXT = CW'(MAX_TAGS);

  // parser phases
  localparam logic [2:0] P_ADDR_START = 3'd0;
  localparam logic [2:0] P_ADDR       = 3'd1;
  localparam logic [2:0] P_TAG_START  = 3'd2;
  localparam logic [2:0] P_TAGS       = 3'd3;
  localparam logic [2:0] P_ARG_VAL    = 3'd4;
  localparam logic [2:0] P_ARG_STR    = 3'd5;
  localparam logic [2:0] P_DRAIN      = 3'd6;

  // engine steps
  localparam logic [1:0] E_MAIN = 2'd0;
  localparam logic [1:0] E_ADV  = 2'd1;
  localparam logic [1:0] E_ERR  = 2'd2;

  logic [1:0]    estate, estate_next;
  logic [2:0]    phase, phase_next;
  logic [CW-1:0] tag_count, tag_count_next;
  logic [CW-1:0] current_arg, current_arg_next;
  logic [63:0]   acc, acc_next;
  logic [3:0]    seen, seen_next;
  logic [6:0]    cur_tag, cur_tag_next;
  logic          eop_r, eop_r_next;
  logic [4:0]    cnt, cnt_next;

  logic [6:0]    tag_mem [MAX_TAGS];
  logic [6:0]    rd_data;
  logic [AW-1:0] rd_addr, rd_addr_calc, wr_addr;
  logic [6:0]    wr_data;
  logic          we;

  osc_pkg::result_t hold;
  logic             hold_v, hold_done;

  logic          gen, fin, adv, err, do_clear;
  logic [2:0]    r_kind;
  logic [6:0]    r_tag;
  logic [63:0]   r_val;
  logic [3:0]    r_idx;
  logic [CW+3:0] arg_ext;
  logic [CW-1:0] arg_inc;
  logic [63:0]   acc_shift;
  logic [3:0]    seen_inc;
  logic [2:0]    cur_cls, rd_cls;
  logic          active, out_free, can_step, step, g, f, push, push_last;
  logic [4:0]    cnt_eff;

  assign arg_ext   = {4'd0, current_arg};
  assign arg_inc   = current_arg + 1'b1;
  assign acc_shift = {acc[55:0], q_item.data};
  assign seen_inc  = seen + 4'd1;
  assign cur_cls   = osc_pkg::tag_class({1'b0, cur_tag});
  assign rd_cls    = osc_pkg::tag_class({1'b0, rd_data});

  always_comb begin
    estate_next      = estate;
    phase_next       = phase;
    tag_count_next   = tag_count;
    current_arg_next = current_arg;
    acc_next         = acc;
    seen_next        = seen;
    cur_tag_next     = cur_tag;
    eop_r_next       = eop_r;
    gen              = 1'b0;
    fin              = 1'b0;
    adv              = 1'b0;
    err              = 1'b0;
    do_clear         = 1'b0;
    r_kind           = osc_pkg::K_ADDR;
    r_tag            = 7'd0;
    r_idx            = 4'd0;
    r_val            = 64'd0;
    we               = 1'b0;
    wr_addr          = tag_count[AW-1:0];
    wr_data          = q_item.data[6:0];
    rd_addr_calc     = current_arg[AW-1:0];

    unique case (estate)
      E_MAIN: begin
        unique case (phase)
          P_ADDR_START: begin
            if (q_item.is_slash) begin
              gen        = 1'b1;
              r_val      = {56'd0, q_item.data};
              phase_next = P_ADDR;
            end else begin
              err = 1'b1;
            end
          end
          P_ADDR: begin
            if (q_item.is_zero) begin
              phase_next = P_TAG_START;
            end else begin
              gen   = 1'b1;
              r_val = {56'd0, q_item.data};
            end
          end
          P_TAG_START: begin
            if (q_item.offset == 2'd0) begin
              if (q_item.is_comma) begin
                phase_next     = P_TAGS;
                tag_count_next = '0;
              end else begin
                err = 1'b1;
              end
            end
          end
          P_TAGS: begin
            if (q_item.is_zero) begin
              current_arg_next = '0;
              adv              = 1'b1;
            end else if (q_item.cls == osc_pkg::CL_UNKNOWN || tag_count >= MAXT) begin
              err = 1'b1;
            end else begin
              we             = 1'b1;
              tag_count_next = tag_count + 1'b1;
            end
          end
          P_ARG_VAL: begin
            if (seen != 4'd0 || q_item.offset == 2'd0) begin
              if (current_arg >= MAXT) begin
                err = 1'b1;
              end else begin
                acc_next  = acc_shift;
                seen_next = seen_inc;
                if (seen_inc >= ((cur_cls == osc_pkg::CL_EIGHT) ? 4'd8 : 4'd4)) begin
                  gen    = 1'b1;
                  r_kind = osc_pkg::K_ARG;
                  r_tag  = cur_tag;
                  r_idx  = arg_ext[3:0];
                  if (cur_tag == osc_pkg::TAG_C) begin
                    r_val = {57'd0, q_item.data[6:0] & osc_pkg::LOW7};
                  end else if (cur_cls == osc_pkg::CL_FOUR) begin
                    r_val = {32'd0, acc_shift[31:0]};
                  end else begin
                    r_val = acc_shift;
                  end
                  current_arg_next = arg_inc;
                  adv              = 1'b1;
                end
              end
            end
          end
          P_ARG_STR: begin
            if (seen != 4'd0 || q_item.offset == 2'd0) begin
              if (current_arg >= MAXT) begin
                err = 1'b1;
              end else begin
                seen_next = 4'd1;
                gen       = 1'b1;
                r_kind    = osc_pkg::K_STR;
                r_tag     = cur_tag;
                r_idx     = arg_ext[3:0];
                r_val     = {56'd0, q_item.data};
                if (q_item.is_zero) begin
                  current_arg_next = arg_inc;
                  adv              = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase

        if (err) begin
          gen        = 1'b1;
          r_kind     = osc_pkg::K_ERR;
          r_tag      = 7'd0;
          r_idx      = 4'd0;
          r_val      = 64'd0;
          phase_next = P_DRAIN;
        end

        if (adv) begin
          // tag lookup for the next argument is issued now and its registered result is examined in E_ADV
          estate_next  = E_ADV;
          eop_r_next   = q_item.eop;
          rd_addr_calc = current_arg_next[AW-1:0];
        end else if (q_item.eop) begin
          if (phase_next != P_DRAIN && gen) begin
            estate_next = E_ERR;
          end else begin
            if (phase_next != P_DRAIN) begin
              gen    = 1'b1;
              r_kind = osc_pkg::K_ERR;
            end
            do_clear = 1'b1;
            fin      = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end

      E_ADV: begin
        if (current_arg < tag_count) begin
          if (rd_cls == osc_pkg::CL_ZERO) begin
            gen    = 1'b1;
            r_kind = osc_pkg::K_ARG;
            r_tag  = rd_data;
            r_idx  = arg_ext[3:0];
            if (rd_data == osc_pkg::TAG_T) begin
              r_val = 64'd1;
            end else if (rd_data == osc_pkg::TAG_I) begin
              r_val = osc_pkg::INF_BITS;
            end
            current_arg_next = arg_inc;
            rd_addr_calc     = arg_inc[AW-1:0];
          end else begin
            phase_next   = (rd_cls == osc_pkg::CL_STR) ? P_ARG_STR : P_ARG_VAL;
            cur_tag_next = rd_data;
            acc_next     = 64'd0;
            seen_next    = 4'd0;
            estate_next  = E_MAIN;
            fin          = 1'b1;
            if (eop_r) begin
              gen      = 1'b1;
              r_kind   = osc_pkg::K_ERR;
              do_clear = 1'b1;
            end
          end
        end else begin
          gen         = 1'b1;
          r_kind      = osc_pkg::K_DONE;
          phase_next  = P_DRAIN;
          estate_next = E_MAIN;
          fin         = 1'b1;
          do_clear    = eop_r;
        end
      end

      E_ERR: begin
        gen         = 1'b1;
        r_kind      = osc_pkg::K_ERR;
        do_clear    = 1'b1;
        fin         = 1'b1;
        estate_next = E_MAIN;
      end

      default: begin
        estate_next = E_MAIN;
      end
    endcase

    if (do_clear) begin
      phase_next       = P_ADDR_START;
      tag_count_next   = '0;
      current_arg_next = '0;
      acc_next         = 64'd0;
      seen_next        = 4'd0;
    end
  end

  // engine advances only when the hold stage can move on
  assign active   = (estate != E_MAIN) || q_valid;
  assign out_free = !out_valid || out_ready;
  assign can_step = !hold_v || out_free;
  assign step     = active && can_step;
  assign q_pop    = step && (estate == E_MAIN);

  assign cnt_eff   = (estate == E_MAIN) ? 5'd0 : cnt;
  assign g         = step && gen && (cnt_eff < osc_pkg::MAX_RESULTS);
  assign f         = step && fin;
  assign push      = hold_v && (hold_done || g || f) && out_free;
  assign push_last = hold_done || (f && !g);
  assign rd_addr   = step ? rd_addr_calc : current_arg[AW-1:0];

  always_ff @(posedge clk) begin
    if (step && we) begin
      tag_mem[wr_addr] <= wr_data;
    end
    rd_data <= tag_mem[rd_addr];
  end

  always_comb begin
    cnt_next = cnt;
    if (step) begin
      cnt_next = cnt_eff + {4'd0, g};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estate      <= E_MAIN;
      phase       <= P_ADDR_START;
      tag_count   <= '0;
      current_arg <= '0;
      seen        <= 4'd0;
      cnt         <= 5'd0;
    end else if (step) begin
      estate      <= estate_next;
      phase       <= phase_next;
      tag_count   <= tag_count_next;
      current_arg <= current_arg_next;
      seen        <= seen_next;
      cnt         <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc     <= acc_next;
      cur_tag <= cur_tag_next;
      eop_r   <= eop_r_next;
    end
  end

  // hold stage keeps the newest result until it is known whether it closes the run
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      hold_done <= 1'b0;
    end else if (g) begin
      hold_v    <= 1'b1;
      hold_done <= f;
    end else if (push) begin
      hold_v    <= 1'b0;
      hold_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (g) begin
      hold.kind <= r_kind;
      hold.tag  <= r_tag;
      hold.idx  <= r_idx;
      hold.val  <= r_val;
      hold.last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res      <= hold;
      out_res.last <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/osc_message_stream_parser_core.sv =====
// path: a byte waits in the queue; its result passes the hold stage and the output register
// throughput: one byte per cycle while m_tready keeps up and bytes cause at most one result
//   and need no tag lookup; a byte that ends the tag list or an argument moves the engine to
//   a tag memory read step, which also emits each zero-size tag (T F N I) that follows; an
//   end mark that adds a truncation error after another result passes through an error step
// reset: synchronous active-high rst returns to expecting an address; tag memory is not cleared
`default_nettype none

module osc_message_stream_parser_core #(
  parameter int MAX_TAGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_packet
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [6:0] type_tag, [10:7] arg_index, [74:11] value, rest 0
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast    // last_of_run
);

  osc_pkg::item_t   push_item;
  osc_pkg::item_t   head_item;
  osc_pkg::result_t res;
  logic             q_full, q_push, q_valid, q_pop;

  // front: takes bytes, tracks alignment offset, classifies
  osc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // short queue decouples byte intake from argument processing
  osc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (push_item),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (head_item)
  );

  // back: parser state, tag memory, argument assembly and result output
  osc_back #(
    .MAX_TAGS (MAX_TAGS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // pack result fields onto the master side
  assign m_tdata = {5'd0, res.val, res.idx, res.tag};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

`default_nettype wire
